FILE: design/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotation block.
package qvr_pkg;

	localparam int DATA_WIDTH_DEF     = 16;
	localparam int QUAT_FRAC_BITS_DEF = 14;

	localparam int QUAT_W    = 16;             // quaternion register width
	localparam int PROD_W    = 2 * QUAT_W;     // one quaternion product
	localparam int MAT_W     = 2 * QUAT_W + 2; // rotation matrix entry
	localparam int LO_W      = 16;             // low slice of a coordinate
	localparam int CFG_IDX_W = 2;
	localparam int MAT_LAT   = 2;              // cycles to rebuild the matrix
	localparam int BUSY_W    = $clog2(MAT_LAT + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_W,
		REG_QUAT_X,
		REG_QUAT_Y,
		REG_QUAT_Z
	} cfg_reg_t;

	typedef struct packed {
		logic signed [QUAT_W-1:0] w;
		logic signed [QUAT_W-1:0] x;
		logic signed [QUAT_W-1:0] y;
		logic signed [QUAT_W-1:0] z;
	} quat_t;

	typedef logic signed [MAT_W-1:0] mat_elem_t;

	// load enables of the per-row datapath stages
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	// coordinates are sign extended to at least one bit above the low slice
	function automatic int vec_w(input int dw);
		return (dw > LO_W) ? dw : LO_W + 1;
	endfunction

endpackage

FILE: design/qvr_matrix.sv
// Builds the unnormalized rotation matrix of the loaded quaternion in two stages.
module qvr_matrix (
	input  logic               clk,
	input  qvr_pkg::quat_t     q,
	output qvr_pkg::mat_elem_t r [3][3]
);
	import qvr_pkg::*;

	typedef logic signed [PROD_W-1:0] prod_t;

	prod_t ww_q, aa_q, bb_q, cc_q;
	prod_t ab_q, wc_q, ac_q, wb_q, bc_q, wa_q;
	mat_elem_t r_q [3][3];

	always_ff @(posedge clk) begin
		ww_q <= PROD_W'(q.w) * PROD_W'(q.w);
		aa_q <= PROD_W'(q.x) * PROD_W'(q.x);
		bb_q <= PROD_W'(q.y) * PROD_W'(q.y);
		cc_q <= PROD_W'(q.z) * PROD_W'(q.z);
		ab_q <= PROD_W'(q.x) * PROD_W'(q.y);
		wc_q <= PROD_W'(q.w) * PROD_W'(q.z);
		ac_q <= PROD_W'(q.x) * PROD_W'(q.z);
		wb_q <= PROD_W'(q.w) * PROD_W'(q.y);
		bc_q <= PROD_W'(q.y) * PROD_W'(q.z);
		wa_q <= PROD_W'(q.w) * PROD_W'(q.x);
	end

	always_ff @(posedge clk) begin
		r_q[0][0] <= MAT_W'(ww_q) + MAT_W'(aa_q) - MAT_W'(bb_q) - MAT_W'(cc_q);
		r_q[1][1] <= MAT_W'(ww_q) - MAT_W'(aa_q) + MAT_W'(bb_q) - MAT_W'(cc_q);
		r_q[2][2] <= MAT_W'(ww_q) - MAT_W'(aa_q) - MAT_W'(bb_q) + MAT_W'(cc_q);
		r_q[0][1] <= (MAT_W'(ab_q) - MAT_W'(wc_q)) <<< 1;
		r_q[0][2] <= (MAT_W'(ac_q) + MAT_W'(wb_q)) <<< 1;
		r_q[1][0] <= (MAT_W'(ab_q) + MAT_W'(wc_q)) <<< 1;
		r_q[1][2] <= (MAT_W'(bc_q) - MAT_W'(wa_q)) <<< 1;
		r_q[2][0] <= (MAT_W'(ac_q) - MAT_W'(wb_q)) <<< 1;
		r_q[2][1] <= (MAT_W'(bc_q) + MAT_W'(wa_q)) <<< 1;
	end

	assign r = r_q;

endmodule

FILE: design/qvr_row.sv
// One output coordinate: matrix row times vector, rounding and saturation.
module qvr_row #(
	parameter int DATA_WIDTH     = qvr_pkg::DATA_WIDTH_DEF,
	parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  qvr_pkg::pipe_en_t      en,
	input  qvr_pkg::mat_elem_t     r [3],
	input  logic [qvr_pkg::LO_W-1:0] v_lo [3],
	input  logic signed [qvr_pkg::vec_w(DATA_WIDTH)-qvr_pkg::LO_W-1:0] v_hi [3],
	output logic signed [DATA_WIDTH-1:0] rot,
	output logic                   clip
);
	import qvr_pkg::*;

	localparam int VEC_W = vec_w(DATA_WIDTH);
	localparam int HI_W  = VEC_W - LO_W;
	localparam int SHIFT = 2 * QUAT_FRAC_BITS;
	localparam int PL_W  = MAT_W + LO_W + 1;
	localparam int PH_W  = MAT_W + HI_W;
	localparam int LS_W  = ((PL_W + 2 > SHIFT + 1) ? PL_W + 2 : SHIFT + 1) + 1;
	localparam int HS_W  = PH_W + 2;
	localparam int TW    = ((HS_W + LO_W > LS_W) ? HS_W + LO_W : LS_W) + 1;

	localparam logic signed [LS_W-1:0] HALF = LS_W'(1) <<< (SHIFT - 1);
	localparam logic signed [TW-1:0]   MAXV = (TW'(1) <<< (DATA_WIDTH - 1)) - TW'(1);
	localparam logic signed [TW-1:0]   MINV = ~MAXV;

	logic signed [PL_W-1:0] p_lo_s2 [3];
	logic signed [PH_W-1:0] p_hi_s2 [3];
	logic signed [LS_W-1:0] lo_sum_s3;
	logic signed [HS_W-1:0] hi_sum_s3;
	logic signed [DATA_WIDTH-1:0] rot_s4;
	logic                   clip_s4;

	logic signed [TW-1:0] total;
	logic signed [TW-1:0] scaled;
	logic signed [DATA_WIDTH-1:0] sat_val;
	logic                   sat_hit;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int j = 0; j < 3; j++) begin
				p_lo_s2[j] <= PL_W'(r[j]) * PL_W'($signed({1'b0, v_lo[j]}));
				p_hi_s2[j] <= PH_W'(r[j]) * PH_W'(v_hi[j]);
			end
		end
	end

	// rounding offset rides with the low partial sums
	always_ff @(posedge clk) begin
		if (en.s3) begin
			lo_sum_s3 <= LS_W'(p_lo_s2[0]) + LS_W'(p_lo_s2[1]) + LS_W'(p_lo_s2[2]) + HALF;
			hi_sum_s3 <= HS_W'(p_hi_s2[0]) + HS_W'(p_hi_s2[1]) + HS_W'(p_hi_s2[2]);
		end
	end

	always_comb begin
		total  = (TW'(hi_sum_s3) <<< LO_W) + TW'(lo_sum_s3);
		scaled = total >>> SHIFT;
		if (scaled > MAXV) begin
			sat_val = MAXV[DATA_WIDTH-1:0];
			sat_hit = 1'b1;
		end else if (scaled < MINV) begin
			sat_val = MINV[DATA_WIDTH-1:0];
			sat_hit = 1'b1;
		end else begin
			sat_val = scaled[DATA_WIDTH-1:0];
			sat_hit = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			rot_s4  <= sat_val;
			clip_s4 <= sat_hit;
		end
	end

	assign rot  = rot_s4;
	assign clip = clip_s4;

endmodule

FILE: design/quaternion_vector_rotation.sv
// Top level: rotates a vector stream by the loaded quaternion, q * v * conj(q).
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  vec     | vec_valid, vec_stall | vec_x, vec_y, vec_z
//  rot     | rot_valid, rot_stall | rot_x, rot_y, rot_z, saturated
//  cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data (quat w,x,y,z)
//
// One vector per cycle while vec_stall is low; each vec beat passes through four register
// stages (input register, products, partial sums, round/saturate output) to rot_valid.
// The matrix is rebuilt from the quaternion through its product and sum registers: vec_stall
// holds high for the whole rebuild after reset and after every cfg beat, and during each cfg beat.
// A stalled output lets earlier stages keep filling until each holds a beat.
module quaternion_vector_rotation #(
	parameter int DATA_WIDTH     = qvr_pkg::DATA_WIDTH_DEF,
	parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              vec_valid,
	output logic                              vec_stall,
	input  logic signed [DATA_WIDTH-1:0]      vec_x,
	input  logic signed [DATA_WIDTH-1:0]      vec_y,
	input  logic signed [DATA_WIDTH-1:0]      vec_z,

	output logic                              rot_valid,
	input  logic                              rot_stall,
	output logic signed [DATA_WIDTH-1:0]      rot_x,
	output logic signed [DATA_WIDTH-1:0]      rot_y,
	output logic signed [DATA_WIDTH-1:0]      rot_z,
	output logic                              saturated,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [qvr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qvr_pkg::QUAT_W-1:0]        cfg_data
);
	import qvr_pkg::*;

	localparam int VEC_W = vec_w(DATA_WIDTH);
	localparam int HI_W  = VEC_W - LO_W;
	localparam logic [QUAT_W-1:0] QUAT_ONE = QUAT_W'(64'd1 << QUAT_FRAC_BITS);

	quat_t     quat_q;
	logic [BUSY_W-1:0] busy_q;
	mat_elem_t mat [3][3];

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic vec_take;
	pipe_en_t en;

	logic signed [VEC_W-1:0] vec_ext [3];
	logic [LO_W-1:0]         v_lo_s1 [3];
	logic signed [HI_W-1:0]  v_hi_s1 [3];

	logic signed [DATA_WIDTH-1:0] rot [3];
	logic [2:0]              clip;

	// configuration registers; a write restarts the matrix rebuild
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.w <= QUAT_ONE;
			quat_q.x <= '0;
			quat_q.y <= '0;
			quat_q.z <= '0;
			busy_q   <= BUSY_W'(MAT_LAT);
		end else begin
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					REG_QUAT_W: quat_q.w <= cfg_data;
					REG_QUAT_X: quat_q.x <= cfg_data;
					REG_QUAT_Y: quat_q.y <= cfg_data;
					REG_QUAT_Z: quat_q.z <= cfg_data;
					default: ;
				endcase
				busy_q <= BUSY_W'(MAT_LAT);
			end else if (busy_q != '0) begin
				busy_q <= busy_q - BUSY_W'(1);
			end
		end
	end

	assign cfg_ready = 1'b1;

	qvr_matrix u_matrix (
		.clk (clk),
		.q   (quat_q),
		.r   (mat)
	);

	// a stage loads when it is empty or its contents move on
	assign rdy4 = !valid_s4 || !rot_stall;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign vec_stall = !rdy1 || (busy_q != '0) || cfg_valid;
	assign vec_take  = vec_valid && !vec_stall;

	assign en.s2 = rdy2;
	assign en.s3 = rdy3;
	assign en.s4 = rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= vec_take;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	assign vec_ext[0] = VEC_W'(vec_x);
	assign vec_ext[1] = VEC_W'(vec_y);
	assign vec_ext[2] = VEC_W'(vec_z);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			for (int j = 0; j < 3; j++) begin
				v_lo_s1[j] <= vec_ext[j][LO_W-1:0];
				v_hi_s1[j] <= vec_ext[j][VEC_W-1:LO_W];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		qvr_row #(
			.DATA_WIDTH     (DATA_WIDTH),
			.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
		) u_row (
			.clk  (clk),
			.en   (en),
			.r    (mat[i]),
			.v_lo (v_lo_s1),
			.v_hi (v_hi_s1),
			.rot  (rot[i]),
			.clip (clip[i])
		);
	end

	assign rot_valid = valid_s4;
	assign rot_x     = rot[0];
	assign rot_y     = rot[1];
	assign rot_z     = rot[2];
	assign saturated = |clip;

endmodule

FILE: verif/tb_quaternion_vector_rotation.sv
// Self-checking testbench for quaternion_vector_rotation: directed and random vectors.
module tb_quaternion_vector_rotation;
	timeunit 1ns;
	timeprecision 1ps;

	import qvr_pkg::*;

	localparam int DW         = DATA_WIDTH_DEF;
	localparam int QF         = QUAT_FRAC_BITS_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int RAND_ITEMS = 700;

	typedef struct {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
	} vec_t;

	typedef struct {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
		logic                 sat;
	} rot_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 vec_valid = 1'b0;
	logic                 vec_stall;
	logic signed [DW-1:0] vec_x = '0;
	logic signed [DW-1:0] vec_y = '0;
	logic signed [DW-1:0] vec_z = '0;
	logic                 rot_valid;
	logic                 rot_stall = 1'b0;
	logic signed [DW-1:0] rot_x;
	logic signed [DW-1:0] rot_y;
	logic signed [DW-1:0] rot_z;
	logic                 saturated;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [QUAT_W-1:0]    cfg_data = '0;

	quat_t quat_model;
	rot_t  expected_rot[$];
	int    error_count = 0;
	int    idle_cycles = 0;
	int    burst_left = 0;
	int    stall_left = 0;
	int    stall_mode = 0;
	int    stall_phase = 0;

	quaternion_vector_rotation #(
		.DATA_WIDTH(DW),
		.QUAT_FRAC_BITS(QF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.vec_valid(vec_valid),
		.vec_stall(vec_stall),
		.vec_x(vec_x),
		.vec_y(vec_y),
		.vec_z(vec_z),
		.rot_valid(rot_valid),
		.rot_stall(rot_stall),
		.rot_x(rot_x),
		.rot_y(rot_y),
		.rot_z(rot_z),
		.saturated(saturated),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// q * v * conj(q) via the unnormalized rotation matrix, round half up, saturate
	function automatic rot_t rotate_vector(input quat_t q, input vec_t v);
		longint w, a, b, c;
		longint m[3][3];
		longint comp[3];
		longint acc;
		longint hi_lim, lo_lim;
		logic signed [DW-1:0] o[3];
		rot_t r;
		w = longint'(q.w);
		a = longint'(q.x);
		b = longint'(q.y);
		c = longint'(q.z);
		m[0][0] = w*w + a*a - b*b - c*c;
		m[0][1] = 2 * (a*b - w*c);
		m[0][2] = 2 * (a*c + w*b);
		m[1][0] = 2 * (a*b + w*c);
		m[1][1] = w*w - a*a + b*b - c*c;
		m[1][2] = 2 * (b*c - w*a);
		m[2][0] = 2 * (a*c - w*b);
		m[2][1] = 2 * (b*c + w*a);
		m[2][2] = w*w - a*a - b*b + c*c;
		comp[0] = longint'(v.x);
		comp[1] = longint'(v.y);
		comp[2] = longint'(v.z);
		hi_lim = (longint'(1) <<< (DW - 1)) - 1;
		lo_lim = -hi_lim - 1;
		r.sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc = m[i][0] * comp[0] + m[i][1] * comp[1] + m[i][2] * comp[2];
			acc = (acc + (longint'(1) <<< (2*QF - 1))) >>> (2*QF);
			if (acc > hi_lim) begin
				acc = hi_lim;
				r.sat = 1'b1;
			end else if (acc < lo_lim) begin
				acc = lo_lim;
				r.sat = 1'b1;
			end
			o[i] = acc[DW-1:0];
		end
		r.x = o[0];
		r.y = o[1];
		r.z = o[2];
		return r;
	endfunction

	function automatic vec_t make_vec(input int x, input int y, input int z);
		vec_t v;
		v.x = x[DW-1:0];
		v.y = y[DW-1:0];
		v.z = z[DW-1:0];
		return v;
	endfunction

	function automatic quat_t make_quat(input int w, input int x, input int y, input int z);
		quat_t q;
		q.w = w[QUAT_W-1:0];
		q.x = x[QUAT_W-1:0];
		q.y = y[QUAT_W-1:0];
		q.z = z[QUAT_W-1:0];
		return q;
	endfunction

	function automatic quat_t random_unit_quat();
		real c[4];
		real n;
		int  k[4];
		do begin
			n = 0.0;
			for (int i = 0; i < 4; i++) begin
				c[i] = real'(int'($urandom_range(0, 65535)) - 32768) / 32768.0;
				n += c[i] * c[i];
			end
		end while (n < 0.05);
		for (int i = 0; i < 4; i++)
			k[i] = int'(c[i] / $sqrt(n) * 16384.0);
		return make_quat(k[0], k[1], k[2], k[3]);
	endfunction

	function automatic int pick_component();
		int vals[7] = '{-32768, -16384, -11585, 0, 11585, 16384, 32767};
		return vals[$urandom_range(0, 6)];
	endfunction

	function automatic int random_coord(input int mode);
		int ext[4] = '{-32768, 32767, 0, -1};
		case (mode)
			0: return ext[$urandom_range(0, 3)];
			1: return int'($urandom_range(0, 2000)) - 1000;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic vec_t random_vector();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return make_vec(random_coord(0), random_coord(0), random_coord(0));
		if (sel < 3)
			return make_vec(random_coord(1), random_coord(1), random_coord(1));
		return make_vec(random_coord(2), random_coord(2), random_coord(2));
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] rot mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	// sender works in bursts; a gap lowers valid only when the burst is used up
	task automatic send_vector(input vec_t v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 8);
			if (gap > 0) begin
				vec_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		vec_valid <= 1'b1;
		vec_x <= v.x;
		vec_y <= v.y;
		vec_z <= v.z;
		do @(posedge clk); while (vec_stall);
		expected_rot.push_back(rotate_vector(quat_model, v));
		burst_left--;
	endtask

	task automatic drain_results();
		vec_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (expected_rot.size() != 0);
	endtask

	// all four registers in one run of beats; valid stays high between them
	task automatic load_quat(input quat_t q);
		cfg_reg_t regs[4] = '{REG_QUAT_W, REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z};
		logic [QUAT_W-1:0] vals[4];
		vals[0] = q.w;
		vals[1] = q.x;
		vals[2] = q.y;
		vals[3] = q.z;
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		quat_model = q;
	endtask

	task automatic test_reset_identity();
		send_vector(make_vec(0, 0, 0));
		send_vector(make_vec(32767, 32767, 32767));
		send_vector(make_vec(-32768, -32768, -32768));
		send_vector(make_vec(-1, 1, 0));
		send_vector(make_vec(32767, -32768, -1));
		send_vector(make_vec(12345, -23456, 7));
		drain_results();
	endtask

	task automatic test_quat_extremes();
		quat_t qs[3];
		qs[0] = make_quat(-32768, -32768, -32768, -32768);
		qs[1] = make_quat(32767, 32767, 32767, 32767);
		qs[2] = make_quat(-32768, 0, 0, 0);   // |q|^2 = 4, scales by four
		for (int i = 0; i < 3; i++) begin
			load_quat(qs[i]);
			send_vector(make_vec(1, 0, 0));
			send_vector(make_vec(-1, -1, -1));
			send_vector(make_vec(32767, 0, -32768));
			send_vector(make_vec(-32768, 32767, 100));
			drain_results();
		end
	endtask

	task automatic test_quarter_turn();
		// 90 degrees about z; none of these vectors lands on a rounding tie
		load_quat(make_quat(11585, 0, 0, 11585));
		send_vector(make_vec(1000, 0, 0));
		send_vector(make_vec(0, -1, 0));
		send_vector(make_vec(32767, 32767, -32768));
		send_vector(make_vec(-32768, 12345, 32767));
		drain_results();
	endtask

	task automatic test_random_rotations();
		int    sent;
		int    phase_len;
		int    kind;
		bit    paused;
		quat_t q;
		sent = 0;
		paused = 1'b0;
		while (sent < RAND_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind < 6)
				q = random_unit_quat();
			else if (kind < 8)
				q = make_quat($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
			else
				q = make_quat(pick_component(), pick_component(), pick_component(),
					pick_component());
			load_quat(q);
			phase_len = $urandom_range(30, 80);
			for (int i = 0; i < phase_len; i++) begin
				send_vector(random_vector());
				sent++;
				if (!paused && sent >= RAND_ITEMS / 2) begin
					drain_results();
					paused = 1'b1;
				end
			end
			drain_results();
		end
		load_quat(make_quat(16384, 0, 0, 0));
	endtask

	// receiver stall pattern: segments of none, heavy random, periodic, light random
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 120);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			0: rot_stall <= 1'b0;
			1: rot_stall <= 1'($urandom_range(0, 1));
			2: rot_stall <= (stall_phase % 4) != 0;
			default: rot_stall <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		rot_t want;
		if (arst_n && rot_valid && !rot_stall) begin
			if (expected_rot.size() == 0) begin
				report_mismatch("unexpected beat", rot_x, 0);
			end else begin
				want = expected_rot.pop_front();
				if (rot_x !== want.x)
					report_mismatch("rot_x", rot_x, want.x);
				if (rot_y !== want.y)
					report_mismatch("rot_y", rot_y, want.y);
				if (rot_z !== want.z)
					report_mismatch("rot_z", rot_z, want.z);
				if (saturated !== want.sat)
					report_mismatch("saturated", saturated, want.sat);
			end
		end
	end

	always @(posedge clk) begin
		if ((vec_valid && !vec_stall) || (rot_valid && !rot_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		quat_model = make_quat(16384, 0, 0, 0);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_identity();
		test_quat_extremes();
		test_quarter_turn();
		test_random_rotations();
		drain_results();
		repeat (8) @(posedge clk);
		if (error_count == 0 && expected_rot.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
